/* hw/rtl/bmps_pkg.sv */
// Shared types, constants and helpers for the bump map pixel shader.
// No dependencies; used by every RTL file of the block.
package bmps_pkg;

  localparam int COORD_W     = 9;
  localparam int HEIGHT_W    = 8;
  localparam int COLOUR_W    = 24;
  localparam int CFG_W       = 10;
  localparam int ADDR_W      = 2 * CFG_W;   // clamped coord times stride plus column
  localparam int POS_W       = 13;          // signed displaced coordinate
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int LIGHT_DEPTH_DEF = 262144;
  localparam int COORD_BITS_DEF  = 9;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL = CFG_W'(256);

  typedef enum logic [1:0] {
    REG_LIGHT_WIDTH  = 2'd0,
    REG_LIGHT_HEIGHT = 2'd1,
    REG_ROW_STRIDE   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  // stage advance strobes for the address front end
  typedef struct packed {
    logic s1;
    logic s2;
  } adv_t;

  // light map access request leaving the address front end
  typedef struct packed {
    logic                load;
    logic                inrange;
    logic [ADDR_W-1:0]   addr;
    logic [COLOUR_W-1:0] colour;
  } req_t;

  function automatic logic [COLOUR_W-1:0] sat_add_rgb(input logic [COLOUR_W-1:0] a,
                                                      input logic [COLOUR_W-1:0] b);
    logic [COLOUR_W-1:0] r;
    logic [8:0]          s;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
      r[8*i +: 8] = s[8] ? 8'hFF : s[7:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/bump_map_pixel_shader_top.sv */
// Bump map pixel shader, top level: stream ports, APB register file, pipeline control.
// Beats pass address, RAM and blend stages; one per cycle while out_tready is high.
// Throughput is set by the single light map RAM port: one read or one write per cycle.
// Load beats (in_tuser = 1) write the light map and give no output beat.
// Reset (rst_n low, synchronous) empties the pipeline and sets all registers to 256.
// Light map contents are undefined until loaded; there is no clearing pass.
module bump_map_pixel_shader_top #(
  parameter int LIGHT_DEPTH = bmps_pkg::LIGHT_DEPTH_DEF,
  parameter int COORD_BITS  = bmps_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata, low to high: x[8:0], y[17:9], right_green[25:18], right_blue[33:26],
  // left_green[41:34], left_blue[49:42], below_green[57:50], below_blue[65:58],
  // above_green[73:66], above_blue[81:74], colour_word[105:82], zero pad[111:106]
  input  logic [bmps_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,   // action: 0 shade, 1 load light
  // output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bmps_pkg::OUT_TDATA_W-1:0]    out_tdata,  // shaded_pixel[23:0]
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bmps_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [bmps_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [bmps_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CW = bmps_pkg::CFG_W;

  // register file
  logic [CW-1:0]        light_width_r, light_height_r, row_stride_r;
  logic                 cfg_wr;
  bmps_pkg::reg_idx_t   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = bmps_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_width_r  <= bmps_pkg::CFG_RESET_VAL;
      light_height_r <= bmps_pkg::CFG_RESET_VAL;
      row_stride_r   <= bmps_pkg::CFG_RESET_VAL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bmps_pkg::REG_LIGHT_WIDTH:  light_width_r  <= cfg_pwdata[CW-1:0];
        bmps_pkg::REG_LIGHT_HEIGHT: light_height_r <= cfg_pwdata[CW-1:0];
        bmps_pkg::REG_ROW_STRIDE:   row_stride_r   <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bmps_pkg::REG_LIGHT_WIDTH:  cfg_prdata = bmps_pkg::CFG_DATA_W'(light_width_r);
      bmps_pkg::REG_LIGHT_HEIGHT: cfg_prdata = bmps_pkg::CFG_DATA_W'(light_height_r);
      bmps_pkg::REG_ROW_STRIDE:   cfg_prdata = bmps_pkg::CFG_DATA_W'(row_stride_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // pipeline control: each stage moves when it is empty or the next one moves,
  // so bubbles collapse; input fills empty stages while a result waits at the output
  logic                          v1, v2;
  logic                          v3_r, out_valid_r;
  logic                          en3, en4;
  bmps_pkg::adv_t                adv;
  bmps_pkg::req_t                req;
  logic [bmps_pkg::COLOUR_W-1:0] colour3_r, light_rd;
  logic                          inrange3_r;
  logic [bmps_pkg::COLOUR_W-1:0] out_data_r;

  assign en4       = !out_valid_r || out_tready;
  assign en3       = !v3_r || en4;
  assign adv.s2    = !v2 || en3;
  assign adv.s1    = !v1 || !v2 || en3;
  assign in_tready = adv.s1;

  // stages 1-2: displaced, clamped coordinate and light map address
  bmps_addr_gen #(
    .LIGHT_DEPTH (LIGHT_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_addr_gen (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .beat_vld     (in_tvalid),
    .action       (in_tuser),
    .x            (in_tdata[8:0]),
    .y            (in_tdata[17:9]),
    .right_green  (in_tdata[25:18]),
    .right_blue   (in_tdata[33:26]),
    .left_green   (in_tdata[41:34]),
    .left_blue    (in_tdata[49:42]),
    .below_green  (in_tdata[57:50]),
    .below_blue   (in_tdata[65:58]),
    .above_green  (in_tdata[73:66]),
    .above_blue   (in_tdata[81:74]),
    .colour_word  (in_tdata[105:82]),
    .light_width  (light_width_r),
    .light_height (light_height_r),
    .row_stride   (row_stride_r),
    .v1           (v1),
    .v2           (v2),
    .req          (req)
  );

  // stage 3: light map access. Beats reach the RAM in order, at most one per cycle,
  // so a read always sees every earlier load.
  bmps_light_ram #(
    .LIGHT_DEPTH (LIGHT_DEPTH)
  ) u_light_ram (
    .clk     (clk),
    .acc_en  (en3 && v2),
    .req     (req),
    .rd_data (light_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en3) v3_r        <= v2 && !req.load;   // loads end here
      if (en4) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      colour3_r  <= req.colour;
      inrange3_r <= req.inrange;
    end
    // stage 4: saturating blend into the output register
    if (en4) begin
      out_data_r <= bmps_pkg::sat_add_rgb(colour3_r, inrange3_r ? light_rd : '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hw/rtl/bmps_addr_gen.sv */
// Address front end: slope, displacement and clamp for shade beats (stage 1), row address
// and range check (stage 2). Depends on bmps_pkg.
module bmps_addr_gen #(
  parameter int LIGHT_DEPTH = bmps_pkg::LIGHT_DEPTH_DEF,
  parameter int COORD_BITS  = bmps_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmps_pkg::adv_t                    adv,
  input  logic                              beat_vld,
  input  logic                              action,
  input  logic [bmps_pkg::COORD_W-1:0]      x,
  input  logic [bmps_pkg::COORD_W-1:0]      y,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     right_green,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     right_blue,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     left_green,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     left_blue,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     below_green,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     below_blue,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     above_green,
  input  logic [bmps_pkg::HEIGHT_W-1:0]     above_blue,
  input  logic [bmps_pkg::COLOUR_W-1:0]     colour_word,
  input  logic [bmps_pkg::CFG_W-1:0]        light_width,
  input  logic [bmps_pkg::CFG_W-1:0]        light_height,
  input  logic [bmps_pkg::CFG_W-1:0]        row_stride,
  output logic                              v1,
  output logic                              v2,
  output bmps_pkg::req_t                    req
);

  localparam int CW = bmps_pkg::CFG_W;
  localparam int PW = bmps_pkg::POS_W;
  localparam int AW = bmps_pkg::ADDR_W;
  localparam logic [bmps_pkg::COORD_W-1:0] CMASK =
    bmps_pkg::COORD_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [AW:0] DEPTH_LIM = (AW+1)'(LIGHT_DEPTH);

  logic                          v1_r, v2_r;
  logic                          load1_r;
  logic [CW-1:0]                 cx1_r, cy1_r;
  logic [bmps_pkg::COLOUR_W-1:0] colour1_r;
  bmps_pkg::req_t                req2_r;

  logic [bmps_pkg::COORD_W-1:0]  xm, ym;
  logic signed [PW-1:0]          nx, ny;
  logic [CW-1:0]                 cx_nxt, cy_nxt;
  logic [AW-1:0]                 addr_nxt;

  function automatic logic signed [PW-1:0] displace(input logic [7:0] pg, input logic [7:0] pb,
                                                    input logic [7:0] mg, input logic [7:0] mb,
                                                    input logic [bmps_pkg::COORD_W-1:0] c);
    logic signed [PW-1:0] d;
    d = $signed(PW'(pg)) + $signed(PW'(pb)) - $signed(PW'(mg)) - $signed(PW'(mb));
    return (d <<< 1) + $signed(PW'(c));
  endfunction

  // clamp to [0, limit-1]; a zero limit behaves as one
  function automatic logic [CW-1:0] clamp(input logic signed [PW-1:0] v,
                                          input logic [CW-1:0] limit);
    logic [CW-1:0] top;
    top = (limit == '0) ? '0 : limit - CW'(1);
    if (v[PW-1])                              return '0;
    else if (v[PW-2:0] > (PW-1)'(top))        return top;
    else                                      return v[CW-1:0];
  endfunction

  always_comb begin
    xm     = x & CMASK;
    ym     = y & CMASK;
    nx     = displace(right_green, right_blue, left_green, left_blue, xm);
    ny     = displace(below_green, below_blue, above_green, above_blue, ym);
    cx_nxt = action ? CW'(xm) : clamp(nx, light_width);
    cy_nxt = action ? CW'(ym) : clamp(ny, light_height);
  end

  assign addr_nxt = AW'({{CW{1'b0}}, cy1_r} * {{CW{1'b0}}, row_stride}) + AW'(cx1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv.s1) v1_r <= beat_vld;
      if (adv.s2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      load1_r   <= action;
      cx1_r     <= cx_nxt;
      cy1_r     <= cy_nxt;
      colour1_r <= colour_word;
    end
    if (adv.s2) begin
      req2_r.load    <= load1_r;
      req2_r.addr    <= addr_nxt;
      req2_r.inrange <= ({1'b0, addr_nxt} < DEPTH_LIM);
      req2_r.colour  <= colour1_r;
    end
  end

  assign v1  = v1_r;
  assign v2  = v2_r;
  assign req = req2_r;

endmodule

/* hw/rtl/bmps_light_ram.sv */
// Light map store: single-port synchronous RAM, one write or one registered read per cycle.
// Depends on bmps_pkg.
module bmps_light_ram #(
  parameter int LIGHT_DEPTH = bmps_pkg::LIGHT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          acc_en,
  input  bmps_pkg::req_t                req,
  output logic [bmps_pkg::COLOUR_W-1:0] rd_data
);

  localparam int IDX_W = (LIGHT_DEPTH > 1) ? $clog2(LIGHT_DEPTH) : 1;

  logic [bmps_pkg::COLOUR_W-1:0] mem [LIGHT_DEPTH];
  logic [bmps_pkg::COLOUR_W-1:0] rd_data_r;
  logic [IDX_W-1:0]              idx;

  assign idx = req.addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (acc_en && req.load && req.inrange) begin
      mem[idx] <= req.colour;
    end
    if (acc_en && !req.load) begin
      rd_data_r <= mem[idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for bump_map_pixel_shader_top: stream stimulus, APB setup,
// a scoreboard that predicts every shaded pixel from a mirrored light map.
// Depends on bmps_pkg and the shader RTL only.
`timescale 1ns / 100ps

module tb_top;

  localparam int  LIGHT_DEPTH  = bmps_pkg::LIGHT_DEPTH_DEF;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  DRAIN_CYCLES = 12;   // pipeline is 4 deep; loads give no beat
  localparam bit  ACT_SHADE    = 1'b0;
  localparam bit  ACT_LOAD     = 1'b1;

  // Input beat, laid out exactly as in_tdata (x in the low bits).
  typedef struct packed {
    logic [5:0]  pad;
    logic [23:0] colour;
    logic [7:0]  above_blue;
    logic [7:0]  above_green;
    logic [7:0]  below_blue;
    logic [7:0]  below_green;
    logic [7:0]  left_blue;
    logic [7:0]  left_green;
    logic [7:0]  right_blue;
    logic [7:0]  right_green;
    logic [8:0]  y;
    logic [8:0]  x;
  } pixel_beat_t;

  // Receiver stall behavior, switched at random intervals.
  typedef enum logic [1:0] {
    RX_OPEN,     // always ready
    RX_COIN,     // ready half the time
    RX_SPARSE,   // ready only when the 3-bit rx_tick wraps to zero
    RX_MOSTLY    // ready at random with probability 3/4
  } rx_mode_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [bmps_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic                              in_tuser = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [bmps_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                              cfg_psel = 1'b0;
  logic                              cfg_penable = 1'b0;
  logic                              cfg_pwrite = 1'b0;
  logic [bmps_pkg::CFG_ADDR_W-1:0]   cfg_paddr = '0;
  logic [bmps_pkg::CFG_DATA_W-1:0]   cfg_pwdata = '0;
  logic [bmps_pkg::CFG_DATA_W-1:0]   cfg_prdata;
  logic                              cfg_pready;

  // Mirror of the block: light map contents, which entries hold data, registers.
  logic [23:0]  light_mem     [LIGHT_DEPTH];
  bit           light_written [LIGHT_DEPTH];
  logic [9:0]   reg_width  = 10'd256;
  logic [9:0]   reg_height = 10'd256;
  logic [9:0]   reg_stride = 10'd256;

  logic [23:0]  expected_pixels [$];
  int           mismatches  = 0;
  int           burst_left  = 0;
  int           sent_beats  = 0;
  int unsigned  cycle_count = 0;

  rx_mode_t     rx_mode    = RX_OPEN;
  int unsigned  rx_left    = 0;
  logic [2:0]   rx_tick    = '0;

  always #5 clk = ~clk;

  bump_map_pixel_shader_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Displace (x,y) by the neighbour slopes, clamp to the light map size and
  // return the light map address that a shade beat reads.
  function automatic int light_target(input pixel_beat_t b, output int nx, output int ny);
    int wtop;
    int htop;
    nx = 2 * ((int'(b.right_green) - int'(b.left_green)) +
              (int'(b.right_blue) - int'(b.left_blue))) + int'(b.x);
    ny = 2 * ((int'(b.below_green) - int'(b.above_green)) +
              (int'(b.below_blue) - int'(b.above_blue))) + int'(b.y);
    // zero size behaves as size one
    wtop = (reg_width == 10'd0) ? 0 : int'(reg_width) - 1;
    htop = (reg_height == 10'd0) ? 0 : int'(reg_height) - 1;
    if (nx < 0) nx = 0;
    else if (nx > wtop) nx = wtop;
    if (ny < 0) ny = 0;
    else if (ny > htop) ny = htop;
    return ny * int'(reg_stride) + nx;
  endfunction

  function automatic logic [23:0] expected_shade(input pixel_beat_t b);
    int          nx;
    int          ny;
    int          addr;
    int          sum;
    logic [23:0] light;
    logic [23:0] pix;
    addr  = light_target(b, nx, ny);
    // reads past the end of the store see black
    light = (addr < LIGHT_DEPTH) ? light_mem[addr] : 24'h0;
    for (int c = 0; c < 3; c++) begin
      sum = int'(b.colour[8*c +: 8]) + int'(light[8*c +: 8]);
      pix[8*c +: 8] = (sum > 255) ? 8'hFF : 8'(sum);
    end
    return pix;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Random beat; half the time neighbour bytes sit close together so the
  // displaced coordinate often lands inside the map instead of clamping.
  function automatic pixel_beat_t random_beat();
    pixel_beat_t b;
    b             = '0;
    b.x           = 9'($urandom_range(0, 511));
    b.y           = 9'($urandom_range(0, 511));
    b.right_green = 8'($urandom_range(0, 255));
    b.right_blue  = 8'($urandom_range(0, 255));
    b.left_green  = 8'($urandom_range(0, 255));
    b.left_blue   = 8'($urandom_range(0, 255));
    b.below_green = 8'($urandom_range(0, 255));
    b.below_blue  = 8'($urandom_range(0, 255));
    b.above_green = 8'($urandom_range(0, 255));
    b.above_blue  = 8'($urandom_range(0, 255));
    b.colour      = 24'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 1) == 1) begin
      b.left_green  = b.right_green + 8'($urandom_range(0, 6)) - 8'd3;
      b.left_blue   = b.right_blue + 8'($urandom_range(0, 6)) - 8'd3;
      b.above_green = b.below_green + 8'($urandom_range(0, 6)) - 8'd3;
      b.above_blue  = b.below_blue + 8'($urandom_range(0, 6)) - 8'd3;
    end
    return b;
  endfunction

  // Random neighbours with zero net slope, so the read lands on (x,y) clamped.
  function automatic pixel_beat_t flat_beat(input int x, input int y, input logic [23:0] colour);
    pixel_beat_t b;
    b             = random_beat();
    b.x           = 9'(x);
    b.y           = 9'(y);
    b.left_green  = b.right_green;
    b.left_blue   = b.right_blue;
    b.above_green = b.below_green;
    b.above_blue  = b.below_blue;
    b.colour      = colour;
    return b;
  endfunction

  // One beat on the input stream. The sender runs in bursts; a new burst may
  // start after an idle gap. Prediction is updated once the beat is taken.
  task automatic drive_beat(input bit action, input pixel_beat_t b);
    int gap;
    int addr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= action;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_beats++;
    if (action == ACT_LOAD) begin
      addr = int'(b.y) * int'(reg_stride) + int'(b.x);
      // loads past the end of the store are dropped
      if (addr < LIGHT_DEPTH) begin
        light_mem[addr]     = b.colour;
        light_written[addr] = 1'b1;
      end
    end else begin
      expected_pixels.push_back(expected_shade(b));
    end
  endtask

  // Shade beat; if its light entry was never loaded, load it first so the
  // block never reads undefined map contents.
  task automatic send_shade(input pixel_beat_t b);
    int          nx;
    int          ny;
    int          addr;
    pixel_beat_t ld;
    addr = light_target(b, nx, ny);
    if (addr < LIGHT_DEPTH && !light_written[addr]) begin
      ld   = random_beat();
      ld.x = 9'(nx);
      ld.y = 9'(ny);
      drive_beat(ACT_LOAD, ld);
    end
    drive_beat(ACT_SHADE, b);
  endtask

  // Stop sending, wait for every pending pixel, then let trailing loads retire.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready. Upper data bits carry
  // junk; only the low 10 bits belong to the register.
  task automatic write_reg(input bmps_pkg::reg_idx_t idx, input logic [9:0] val);
    logic [31:0] junk;
    junk = $urandom();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {junk[31:10], val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      bmps_pkg::REG_LIGHT_WIDTH:  reg_width  = val;
      bmps_pkg::REG_LIGHT_HEIGHT: reg_height = val;
      bmps_pkg::REG_ROW_STRIDE:   reg_stride = val;
      default: ;        // unmapped index, no effect
    endcase
  endtask

  task automatic set_map(input logic [9:0] w, input logic [9:0] h, input logic [9:0] s);
    wait_drained();
    write_reg(bmps_pkg::REG_LIGHT_WIDTH, w);
    write_reg(bmps_pkg::REG_LIGHT_HEIGHT, h);
    write_reg(bmps_pkg::REG_ROW_STRIDE, s);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset sizes (256 each): corner coordinates, steepest slopes both ways,
  // saturation per channel, load followed at once by a read of the same entry.
  task automatic test_extremes();
    pixel_beat_t b;
    drive_beat(ACT_LOAD, flat_beat(0, 0, 24'h000000));
    drive_beat(ACT_LOAD, flat_beat(255, 255, 24'hFFFFFF));
    drive_beat(ACT_LOAD, flat_beat(511, 511, 24'h123456));
    send_shade(flat_beat(0, 0, 24'hFFFFFF));
    send_shade(flat_beat(511, 511, 24'h010203));      // clamps to 255,255
    b = flat_beat(0, 0, 24'h000000);
    b.right_green = 8'hFF; b.right_blue = 8'hFF; b.left_green  = 8'h00; b.left_blue  = 8'h00;
    b.below_green = 8'hFF; b.below_blue = 8'hFF; b.above_green = 8'h00; b.above_blue = 8'h00;
    send_shade(b);                                     // +1020 both ways
    b = flat_beat(511, 511, 24'h808080);
    b.right_green = 8'h00; b.right_blue = 8'h00; b.left_green  = 8'hFF; b.left_blue  = 8'hFF;
    b.below_green = 8'h00; b.below_blue = 8'h00; b.above_green = 8'hFF; b.above_blue = 8'hFF;
    send_shade(b);                                     // -1020 both ways
    drive_beat(ACT_LOAD, flat_beat(10, 20, 24'h808080));
    send_shade(flat_beat(10, 20, 24'h7E8081));         // no carry, carry, carry
    drive_beat(ACT_LOAD, flat_beat(10, 20, 24'h010101));
    send_shade(flat_beat(10, 20, 24'hFEFFFF));         // sees the overwrite
    b = flat_beat(10, 20, 24'h00FF00);
    b.right_green = 8'd5; b.left_green = 8'd3;         // small step to the right
    send_shade(b);
  endtask

  // Zero sizes clamp everything to column 0, row 0; zero stride folds rows
  // together. A write to the unmapped index must leave all sizes alone.
  task automatic test_zero_size_regs();
    set_map(10'd0, 10'd0, 10'd0);
    write_reg(bmps_pkg::REG_UNUSED, 10'd5);
    send_shade(random_beat());
    send_shade(random_beat());
    drive_beat(ACT_LOAD, flat_beat(7, 3, 24'hA5A5A5));
    drive_beat(ACT_LOAD, flat_beat(0, 5, 24'h3C3C3C));  // lands on entry 0
    send_shade(random_beat());
  endtask

  // Wide stride pushes the bottom rows past the end of the store: such loads
  // vanish and such reads return black.
  task automatic test_beyond_store();
    set_map(10'd512, 10'd512, 10'd1023);
    drive_beat(ACT_LOAD, flat_beat(511, 511, 24'hFFFFFF));
    send_shade(flat_beat(511, 511, 24'h102030));
    drive_beat(ACT_LOAD, flat_beat(0, 256, 24'h405060));
    send_shade(flat_beat(0, 256, 24'h0A0B0C));
    drive_beat(ACT_LOAD, flat_beat(300, 256, 24'hFFFFFF));
    send_shade(flat_beat(300, 256, 24'h112233));
  endtask

  // Random traffic under a series of map sizes, extremes among them.
  // Each phase has a budget of input beats, fill-in loads included.
  // Midway through each phase the sender holds off until all pixels are out.
  task automatic test_random_traffic();
    logic [9:0]  sizes [6][3];
    pixel_beat_t b;
    int          beats;
    int          start;
    bit          held;
    sizes[0] = '{10'd256, 10'd256, 10'd256};
    sizes[1] = '{10'd1,   10'd1,   10'd1};
    sizes[2] = '{10'd512, 10'd512, 10'd512};
    sizes[3] = '{10'd512, 10'd7,   10'd512};
    sizes[4] = '{10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)),
                 10'($urandom_range(1, 512))};
    sizes[5] = '{10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)),
                 10'($urandom_range(1, 512))};
    for (int p = 0; p < 6; p++) begin
      set_map(sizes[p][0], sizes[p][1], sizes[p][2]);
      beats = (p == 1) ? 200 : 300;
      start = sent_beats;
      held  = 1'b0;
      while (sent_beats - start < beats) begin
        if (!held && (sent_beats - start >= beats / 2)) begin
          wait_drained();
          held = 1'b1;
        end
        b = random_beat();
        if ($urandom_range(0, 1) == 1) begin
          // keep the pixel near the map so not every read clamps
          b.x = 9'($urandom_range(0, int'(sizes[p][0]) - 1));
          b.y = 9'($urandom_range(0, int'(sizes[p][1]) - 1));
        end
        if ($urandom_range(0, 99) < 20) drive_beat(ACT_LOAD, b);
        else send_shade(b);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 3'd1;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= (rx_tick == 3'd0);
      default:   out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Every output beat is matched against the oldest predicted pixel.
  always @(posedge clk) begin
    logic [23:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("shaded_pixel: beat with nothing pending, got %06h", out_tdata);
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("shaded_pixel: expected %06h got %06h", want, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_size_regs();
    test_beyond_store();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
